// File: rtl/fmp_pkg.sv
// Shared types and constants of the framed message parser.
package fmp_pkg;

   // Result event codes.
   localparam logic [3:0] EV_CONSUMED    = 4'd0;
   localparam logic [3:0] EV_VERSION     = 4'd1;
   localparam logic [3:0] EV_TYPE        = 4'd2;
   localparam logic [3:0] EV_LENGTH      = 4'd3;
   localparam logic [3:0] EV_PAYLOAD     = 4'd4;
   localparam logic [3:0] EV_DONE        = 4'd5;
   localparam logic [3:0] EV_BAD_HEADER  = 4'd6;
   localparam logic [3:0] EV_BAD_TYPE    = 4'd7;
   localparam logic [3:0] EV_BAD_TRAILER = 4'd8;
   localparam logic [3:0] EV_IGNORED     = 4'd9;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TYPE_CODE_A = 2'd0;
   localparam logic [1:0] CSR_TYPE_CODE_B = 2'd1;
   localparam logic [1:0] CSR_TYPE_CODE_C = 2'd2;

   // Magic bytes of the header and the trailer.
   localparam logic [7:0] MAGIC_HEAD_LO = 8'h51;   // 'Q'
   localparam logic [7:0] MAGIC_HEAD_HI = 8'h47;   // 'G'
   localparam logic [7:0] MAGIC_TAIL_LO = 8'h59;   // 'Y'
   localparam logic [7:0] MAGIC_TAIL_HI = 8'h46;   // 'F'

   localparam int COUNT_W     = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // One classified input byte as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       start_new;
      logic       is_head_lo;
      logic       is_head_hi;
      logic       is_tail_lo;
      logic       is_tail_hi;
   } item_type;

   // Accepted message type codes.
   typedef struct packed {
      logic [31:0] code_a;
      logic [31:0] code_b;
      logic [31:0] code_c;
   } codes_type;

endpackage

// File: rtl/fmp_front.sv
// Front end: takes input beats and tags magic bytes before they are queued.
module fmp_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              queue_full,
   output logic              push,
   output fmp_pkg::item_type push_item
);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.rx_byte    = req_tdata;
      push_item.start_new  = req_tuser;
      push_item.is_head_lo = (req_tdata == fmp_pkg::MAGIC_HEAD_LO);
      push_item.is_head_hi = (req_tdata == fmp_pkg::MAGIC_HEAD_HI);
      push_item.is_tail_lo = (req_tdata == fmp_pkg::MAGIC_TAIL_LO);
      push_item.is_tail_hi = (req_tdata == fmp_pkg::MAGIC_TAIL_HI);
   end

endmodule

// File: rtl/fmp_queue.sv
// Short queue of classified bytes between the front end and the parser.
module fmp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  fmp_pkg::item_type                 push_item,
   input  logic                              pop,
   output logic                              not_empty,
   output logic                              full,
   output logic [fmp_pkg::QUEUE_CW-1:0]      count,
   output fmp_pkg::item_type                 head_item
);

   fmp_pkg::item_type               slot_ff [fmp_pkg::QUEUE_DEPTH];
   logic [fmp_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [fmp_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [fmp_pkg::QUEUE_CW-1:0]    count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == fmp_pkg::QUEUE_CW'(fmp_pkg::QUEUE_DEPTH));
   assign count     = count_ff;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fmp_pkg::QUEUE_AW'(fmp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fmp_pkg::QUEUE_AW'(fmp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/fmp_parser.sv
// Back end: frame parsing state machine with a registered result beat.
module fmp_parser #(
   parameter int EXTEND_BYTES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  fmp_pkg::item_type  item,
   input  fmp_pkg::codes_type codes,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [3:0]         rsp_event,
   output logic [31:0]        rsp_value,
   output logic               rsp_last
);

   localparam logic [3:0] PH_HEADER  = 4'd0;
   localparam logic [3:0] PH_VERSION = 4'd1;
   localparam logic [3:0] PH_TYPE    = 4'd2;
   localparam logic [3:0] PH_EXTEND  = 4'd3;
   localparam logic [3:0] PH_LENGTH  = 4'd4;
   localparam logic [3:0] PH_DATA    = 4'd5;
   localparam logic [3:0] PH_TRAILER = 4'd6;

   localparam logic [fmp_pkg::COUNT_W-1:0] EXT_COUNT = fmp_pkg::COUNT_W'(EXTEND_BYTES);
   localparam logic [3:0] PH_AFTER_TYPE = (EXTEND_BYTES == 0) ? PH_LENGTH : PH_EXTEND;

   logic [3:0]                  phase_ff, phase_in;
   logic [fmp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [31:0]                 acc_ff, acc_in;
   logic [31:0]                 remain_ff, remain_in;
   logic                        halted_ff, halted_in;
   logic                        lead_ok_ff, lead_ok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [3:0]                  event_ff, event_in;
   logic [31:0]                 value_ff, value_in;
   logic                        last_ff, last_in;

   // State as seen by this byte, after a possible restart.
   logic [3:0]                  cur_phase;
   logic [fmp_pkg::COUNT_W-1:0] cur_count;
   logic [31:0]                 cur_acc;
   logic [31:0]                 cur_remain;
   logic                        cur_halted;
   logic [31:0]                 gathered;
   logic [fmp_pkg::COUNT_W-1:0] count_inc;
   logic                        type_match;

   assign pop        = item_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_event  = event_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      cur_phase  = item.start_new ? PH_HEADER : phase_ff;
      cur_count  = item.start_new ? '0 : count_ff;
      cur_acc    = item.start_new ? '0 : acc_ff;
      cur_remain = item.start_new ? '0 : remain_ff;
      cur_halted = item.start_new ? 1'b0 : halted_ff;
      gathered   = cur_acc | (32'(item.rx_byte) << {cur_count[1:0], 3'b000});
      count_inc  = cur_count + 1'b1;
      type_match = (gathered == codes.code_a) || (gathered == codes.code_b) ||
                   (gathered == codes.code_c);

      phase_in   = cur_phase;
      count_in   = cur_count;
      acc_in     = cur_acc;
      remain_in  = cur_remain;
      halted_in  = cur_halted;
      lead_ok_in = lead_ok_ff;
      event_in   = fmp_pkg::EV_CONSUMED;
      value_in   = '0;
      last_in    = 1'b0;

      if (cur_halted) begin
         event_in = fmp_pkg::EV_IGNORED;
      end else begin
         unique case (cur_phase)
            PH_HEADER: begin
               if (cur_count == '0) begin
                  lead_ok_in = item.is_head_lo;
                  count_in   = count_inc;
               end else if (lead_ok_ff && item.is_head_hi) begin
                  phase_in = PH_VERSION;
                  count_in = '0;
                  acc_in   = '0;
               end else begin
                  count_in  = count_inc;
                  event_in  = fmp_pkg::EV_BAD_HEADER;
                  halted_in = 1'b1;
               end
            end
            PH_VERSION: begin
               if (cur_count == '0) begin
                  acc_in   = gathered;
                  count_in = count_inc;
               end else begin
                  event_in = fmp_pkg::EV_VERSION;
                  value_in = {16'h0000, gathered[15:0]};
                  phase_in = PH_TYPE;
                  count_in = '0;
                  acc_in   = '0;
               end
            end
            PH_TYPE: begin
               if (cur_count[1:0] != 2'd3) begin
                  acc_in   = gathered;
                  count_in = count_inc;
               end else if (type_match) begin
                  event_in = fmp_pkg::EV_TYPE;
                  value_in = gathered;
                  phase_in = PH_AFTER_TYPE;
                  count_in = '0;
                  acc_in   = '0;
               end else begin
                  event_in  = fmp_pkg::EV_BAD_TYPE;
                  halted_in = 1'b1;
               end
            end
            PH_EXTEND: begin
               if (count_inc >= EXT_COUNT) begin
                  phase_in = PH_LENGTH;
                  count_in = '0;
                  acc_in   = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_LENGTH: begin
               if (cur_count[1:0] != 2'd3) begin
                  acc_in   = gathered;
                  count_in = count_inc;
               end else begin
                  // A zero length skips the payload and goes to the trailer.
                  event_in  = fmp_pkg::EV_LENGTH;
                  value_in  = gathered;
                  remain_in = gathered;
                  phase_in  = (gathered == '0) ? PH_TRAILER : PH_DATA;
                  count_in  = '0;
                  acc_in    = '0;
               end
            end
            PH_DATA: begin
               event_in = fmp_pkg::EV_PAYLOAD;
               value_in = 32'(item.rx_byte);
               if (cur_remain[31:1] == '0) begin
                  last_in   = 1'b1;
                  remain_in = '0;
                  phase_in  = PH_TRAILER;
                  count_in  = '0;
                  acc_in    = '0;
               end else begin
                  remain_in = cur_remain - 1'b1;
               end
            end
            PH_TRAILER: begin
               if (cur_count == '0) begin
                  lead_ok_in = item.is_tail_lo;
                  count_in   = count_inc;
               end else begin
                  count_in  = count_inc;
                  event_in  = (lead_ok_ff && item.is_tail_hi) ?
                              fmp_pkg::EV_DONE : fmp_pkg::EV_BAD_TRAILER;
                  halted_in = 1'b1;
               end
            end
            default: begin
               phase_in  = PH_HEADER;
               count_in  = '0;
               acc_in    = '0;
               remain_in = '0;
               halted_in = 1'b0;
            end
         endcase
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         acc_ff       <= '0;
         remain_ff    <= '0;
         halted_ff    <= 1'b0;
         lead_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            acc_ff     <= acc_in;
            remain_ff  <= remain_in;
            halted_ff  <= halted_in;
            lead_ok_ff <= lead_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         event_ff <= event_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

endmodule

// File: rtl/framed_message_parser_core.sv
// Each input beat is first written into the byte queue; the parser then registers its result beat.
// Throughput: one byte per cycle while the output is not stalled; the two-entry byte queue and the
// result register decouple the input from the output, so either side may stall without losing a beat.
// Reset (synchronous, active high) empties the queue, drops any pending result, puts the
// parser at the frame header and restores the type codes to 0, 1 and 2.
// Top level of the framed message parser core.
module framed_message_parser_core #(
   parameter int EXTEND_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] start_new
   // Result events.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [3:0]  rsp_tuser,   // [3:0] event_res
   output logic        rsp_tlast,   // payload_last
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // The accepted type codes. The user must change them only while the parser is idle (the block does
   // not enforce this), and the parser reads them directly without any synchronization.
   logic [31:0] code_a_ff, code_b_ff, code_c_ff;
   fmp_pkg::codes_type codes;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_a_ff <= 32'd0;
         code_b_ff <= 32'd1;
         code_c_ff <= 32'd2;
      end else if (csr_we) begin
         case (csr_index)
            fmp_pkg::CSR_TYPE_CODE_A: code_a_ff <= csr_wdata;
            fmp_pkg::CSR_TYPE_CODE_B: code_b_ff <= csr_wdata;
            fmp_pkg::CSR_TYPE_CODE_C: code_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign codes.code_a = code_a_ff;
   assign codes.code_b = code_b_ff;
   assign codes.code_c = code_c_ff;

   // The front end tags each byte with its magic byte matches and pushes it into
   // the queue whenever the queue has room.
   logic                             push;
   logic                             pop;
   logic                             queue_full;
   logic                             queue_not_empty;
   logic [fmp_pkg::QUEUE_CW-1:0]     queue_count;
   fmp_pkg::item_type                push_item;
   fmp_pkg::item_type                head_item;

   fmp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   fmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .count     (queue_count),
      .head_item (head_item)
   );

   // The parser takes one byte from the queue in every cycle in which its result
   // register is empty or being drained, and produces exactly one event per byte.
   fmp_parser #(
      .EXTEND_BYTES (EXTEND_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .codes      (codes),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_event  (rsp_tuser),
      .rsp_value  (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   // The queue never holds more beats than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      queue_count <= fmp_pkg::QUEUE_CW'(fmp_pkg::QUEUE_DEPTH))
      else $error("byte queue count exceeds its depth");

   // A full queue must hold off the input side.
   assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !req_tready)
      else $error("input accepted while the byte queue is full");

   // The last-of-payload mark only ever comes with a payload event.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == fmp_pkg::EV_PAYLOAD))
      else $error("payload last set on a non-payload event");

   // Events other than version, type, length and payload carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != fmp_pkg::EV_VERSION) &&
       (rsp_tuser != fmp_pkg::EV_TYPE) && (rsp_tuser != fmp_pkg::EV_LENGTH) &&
       (rsp_tuser != fmp_pkg::EV_PAYLOAD)) |-> (rsp_tdata == 32'd0))
      else $error("non-zero value on an event that carries none");

endmodule
